// ===== hw/rtl/scanline_run_centroid_classifier_defines.svh =====
// ---------------------------------------------------------------------------
// Scanline run centroid classifier: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by arst_n.
// ---------------------------------------------------------------------------
`ifndef SCANLINE_RUN_CENTROID_CLASSIFIER_DEFINES_SVH
`define SCANLINE_RUN_CENTROID_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define SCRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/scrc_pkg.sv =====
// ---------------------------------------------------------------------------
// Scanline run centroid classifier: package
// Widths, codes, queue entry and status types, and the lane classifier.
// ---------------------------------------------------------------------------
package scrc_pkg;

	localparam int COL_W    = 10;
	localparam int ROW_W    = 10;
	localparam int LEN_W    = 11;
	localparam int SUM_W    = 20;
	localparam int CLS_W    = 2;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;
	localparam int REG_IDX_W = 2;
	localparam int REG_DAT_W = 11;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [COL_W-1:0] LEFT_LIMIT_RST   = 10'd115;
	localparam logic [COL_W-1:0] CENTRE_LIMIT_RST = 10'd320;
	localparam logic [LEN_W-1:0] MAX_RUN_RST      = 11'd80;

	localparam logic [REG_IDX_W-1:0] REG_LEFT_LIMIT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_LIMIT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_RUN      = 2'd2;

	typedef enum logic [CLS_W-1:0] {
		CLS_LEFT   = 2'd0,
		CLS_CENTRE = 2'd1,
		CLS_RIGHT  = 2'd2
	} lane_class_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		logic [COL_W-1:0] left_limit;
		logic [COL_W-1:0] centre_limit;
		logic [LEN_W-1:0] max_run_width;
	} cfg_t;

	// one closed run; alt marks the one-pixel run opened on the row end
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [LEN_W-1:0] len;
		logic [ROW_W-1:0] y;
		logic             alt_vld;
		logic [COL_W-1:0] alt_col;
	} job_t;

	typedef struct packed {
		logic emit;
		lane_class_t cls;
	} verdict_t;

	typedef struct packed {
		logic run_open;
		logic push;
	} fr_status_t;

	typedef struct packed {
		logic fin;
		logic load;
	} bk_status_t;

	function automatic verdict_t classify(logic [COL_W-1:0] mean, logic [LEN_W-1:0] len,
			cfg_t cfg);
		verdict_t v;
		v.emit = 1'b1;
		v.cls  = CLS_RIGHT;
		if (mean < cfg.left_limit) begin
			v.cls = CLS_LEFT;
		end else if (mean < cfg.centre_limit) begin
			v.cls = CLS_CENTRE;
		end else if (len >= cfg.max_run_width) begin
			v.emit = 1'b0;
		end
		return v;
	endfunction

endpackage

// ===== hw/rtl/scrc_front.sv =====
// ---------------------------------------------------------------------------
// Scanline run centroid classifier: front end
// Track the open run per pixel and queue each run as it closes.
// ---------------------------------------------------------------------------
module scrc_front #(
	parameter int MAX_WIDTH = scrc_pkg::DEF_MAX_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic                      pixel_on,
	input  logic [scrc_pkg::COL_W-1:0] column,
	input  logic [scrc_pkg::ROW_W-1:0] row_y,
	input  logic                      row_end,
	output scrc_pkg::job_t            job,
	output scrc_pkg::fr_status_t      status
);
	import scrc_pkg::*;

	localparam logic [12:0] MaxW = 13'(MAX_WIDTH);

	logic [SUM_W-1:0] run_sum_q;
	logic [LEN_W-1:0] run_len_q;
	logic [COL_W-1:0] prev_col_q;

	logic             on_eff;
	logic             open;
	logic             cont;
	logic [SUM_W-1:0] sum_n;
	logic [LEN_W-1:0] len_n;
	logic             push;

	assign on_eff = pixel_on && ({3'b000, column} < MaxW);
	assign open   = (run_len_q != '0);
	assign cont   = on_eff && open && ({1'b0, prev_col_q} + 11'd1 == {1'b0, column});

	always_comb begin
		sum_n       = run_sum_q;
		len_n       = run_len_q;
		push        = 1'b0;
		job.sum     = run_sum_q;
		job.len     = run_len_q;
		job.y       = row_y;
		job.alt_vld = 1'b0;
		job.alt_col = column;
		if (on_eff) begin
			if (cont) begin
				sum_n = run_sum_q + SUM_W'(column);
				len_n = run_len_q + 11'd1;
			end else begin
				sum_n = SUM_W'(column);
				len_n = 11'd1;
			end
			if (row_end) begin
				push = 1'b1;
				if (cont || !open) begin
					job.sum = sum_n;
					job.len = len_n;
				end else begin
					job.alt_vld = 1'b1;
				end
				len_n = '0;
			end else begin
				push = !cont && open;
			end
		end else begin
			push  = open;
			len_n = '0;
		end
	end

	assign status.run_open = open;
	assign status.push     = take && push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q <= '0;
		end else if (take) begin
			run_len_q <= len_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			run_sum_q <= sum_n;
			if (on_eff) begin
				prev_col_q <= column;
			end
		end
	end

endmodule

// ===== hw/rtl/scrc_queue.sv =====
// ---------------------------------------------------------------------------
// Scanline run centroid classifier: run queue
// Short first-in first-out store of closed runs between front and back.
// ---------------------------------------------------------------------------
module scrc_queue #(
	parameter int DEPTH = scrc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scrc_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           vld,
	output scrc_pkg::job_t rd_job
);
	import scrc_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full   = (count_q == CntW'(DEPTH));
	assign vld    = (count_q != '0);
	assign rd_job = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== hw/rtl/scrc_back.sv =====
// ---------------------------------------------------------------------------
// Scanline run centroid classifier: back end
// Divide each queued run sum by its length, class the mean, register any emitted result.
// ---------------------------------------------------------------------------
module scrc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scrc_pkg::cfg_t               cfg,
	input  logic                         q_vld,
	input  scrc_pkg::job_t               q_job,
	output logic                         q_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [scrc_pkg::M_DATA_W-1:0] m_tdata,
	output logic [scrc_pkg::CLS_W-1:0]    m_tuser,
	output scrc_pkg::bk_status_t         status
);
	import scrc_pkg::*;

	localparam int CntW = $clog2(COL_W);

	back_state_t      st_q, st_n;
	job_t             job_q;
	logic [LEN_W-1:0] rem_q;
	logic [COL_W-1:0] dvd_q;
	logic [COL_W-1:0] quo_q;
	logic [CntW-1:0]  cnt_q;

	logic             out_vld_q;
	logic [COL_W-1:0] out_x_q;
	logic [ROW_W-1:0] out_y_q;
	lane_class_t      out_cls_q;

	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   diff;
	logic             fits;
	verdict_t         v_main;
	verdict_t         v_alt;
	logic             emit;
	logic [COL_W-1:0] res_x;
	lane_class_t      res_cls;
	logic             can_load;
	logic             load;
	logic             start;

	assign trial = {rem_q, dvd_q[COL_W-1]};
	assign diff  = trial - {1'b0, job_q.len};
	assign fits  = (trial >= {1'b0, job_q.len});

	assign v_main   = classify(quo_q, job_q.len, cfg);
	assign v_alt    = classify(job_q.alt_col, 11'd1, cfg);
	assign can_load = !out_vld_q || m_tready;

	always_comb begin
		emit    = 1'b0;
		res_x   = quo_q;
		res_cls = v_main.cls;
		if (v_main.emit) begin
			emit = 1'b1;
		end else if (job_q.alt_vld && v_alt.emit) begin
			emit    = 1'b1;
			res_x   = job_q.alt_col;
			res_cls = v_alt.cls;
		end
	end

	always_comb begin
		st_n  = st_q;
		start = 1'b0;
		load  = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (q_vld) begin
					start = 1'b1;
					st_n  = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == CntW'(COL_W - 1)) begin
					st_n = BK_FIN;
				end
			end
			BK_FIN: begin
				if (!emit) begin
					st_n = BK_IDLE;
				end else if (can_load) begin
					load = 1'b1;
					st_n = BK_IDLE;
				end
			end
			default: st_n = BK_IDLE;
		endcase
	end

	assign q_pop       = start;
	assign status.fin  = (st_q == BK_FIN);
	assign status.load = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= BK_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q <= q_job;
			rem_q <= {1'b0, q_job.sum[SUM_W-1:COL_W]};
			dvd_q <= q_job.sum[COL_W-1:0];
			quo_q <= '0;
			cnt_q <= '0;
		end else if (st_q == BK_DIV) begin
			rem_q <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			dvd_q <= {dvd_q[COL_W-2:0], 1'b0};
			quo_q <= {quo_q[COL_W-2:0], fits};
			cnt_q <= cnt_q + CntW'(1);
		end
		if (load) begin
			out_x_q   <= res_x;
			out_y_q   <= job_q.y;
			out_cls_q <= res_cls;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(M_DATA_W - COL_W - ROW_W)'(0), out_y_q, out_x_q};
	assign m_tuser  = out_cls_q;

endmodule

// ===== hw/rtl/scanline_run_centroid_classifier.sv =====
// ---------------------------------------------------------------------------
// Scanline run centroid classifier
// Find runs of set pixels in a row, emit each run's mean column and lane class (wide right runs dropped).
// ---------------------------------------------------------------------------
// channel   signals                           carries
// s_*       tvalid tready tdata tlast         pixel_on, column, row_y; tlast = row_end
// m_*       tvalid tready tdata tuser         centre_x, marking_y; tuser = lane_class
// wr_*      wr_en wr_index wr_data            left_limit, centre_limit, max_run_width
//
// Pixels are taken one per cycle while the run queue has room.
// The back end takes each closed run through BK_IDLE to pick it up, BK_DIV
// for the one-bit-per-cycle restoring divider and BK_FIN to class and register.
// The queue holds QUEUE_DEPTH closed runs; s_tready falls only when it is full.
// Reset is asynchronous; there is no clearing pass.
// ---------------------------------------------------------------------------
`include "scanline_run_centroid_classifier_defines.svh"

module scanline_run_centroid_classifier #(
	parameter int MAX_WIDTH   = scrc_pkg::DEF_MAX_WIDTH,
	parameter int QUEUE_DEPTH = scrc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [scrc_pkg::S_DATA_W-1:0]  s_tdata,  // pixel_on, column, row_y
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [scrc_pkg::M_DATA_W-1:0]  m_tdata,  // centre_x, marking_y
	output logic [scrc_pkg::CLS_W-1:0]     m_tuser,  // lane_class
	input  logic                           wr_en,
	input  logic [scrc_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [scrc_pkg::REG_DAT_W-1:0] wr_data
);
	import scrc_pkg::*;

	cfg_t       cfg_q;
	job_t       fr_job;
	job_t       q_job;
	fr_status_t fr_st;
	bk_status_t bk_st;
	logic       take;
	logic       q_full;
	logic       q_vld;
	logic       q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_limit    <= LEFT_LIMIT_RST;
			cfg_q.centre_limit  <= CENTRE_LIMIT_RST;
			cfg_q.max_run_width <= MAX_RUN_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_LEFT_LIMIT:   cfg_q.left_limit    <= wr_data[COL_W-1:0];
				REG_CENTRE_LIMIT: cfg_q.centre_limit  <= wr_data[COL_W-1:0];
				REG_MAX_RUN:      cfg_q.max_run_width <= wr_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	scrc_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.pixel_on (s_tdata[0]),
		.column   (s_tdata[COL_W:1]),
		.row_y    (s_tdata[COL_W+ROW_W:COL_W+1]),
		.row_end  (s_tlast),
		.job      (fr_job),
		.status   (fr_st)
	);

	scrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_st.push),
		.wr_job (fr_job),
		.full   (q_full),
		.pop    (q_pop),
		.vld    (q_vld),
		.rd_job (q_job)
	);

	scrc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_vld    (q_vld),
		.q_job    (q_job),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.status   (bk_st)
	);

	`SCRC_ASSERT_NOW(a_push_room, fr_st.push, !q_full, "run queued while queue full")
	`SCRC_ASSERT_NOW(a_pop_data, q_pop, q_vld, "run taken from empty queue")
	`SCRC_ASSERT_NOW(a_load_fin, bk_st.load, bk_st.fin, "result outside finish")
	`SCRC_ASSERT_NEXT(a_row_close, take && s_tlast, !fr_st.run_open, "run open after row end")

endmodule
